/* hdl/shp_pkg.sv */
`default_nettype none
package shp_pkg;

  // Field widths of the two channels
  localparam int unsigned SHP_BYTE_W  = 8;
  localparam int unsigned SHP_WORD_W  = 64;
  localparam int unsigned SHP_INDEX_W = 3;
  localparam int unsigned SHP_POS_W   = 6;
  localparam int unsigned SHP_ASM_W   = 56;

  // Default depth of the queue between front and back
  localparam int unsigned SHP_QUEUE_DEPTH = 4;

  // Padding marker byte and the word slot that carries the length
  localparam logic [SHP_BYTE_W-1:0]  SHP_PAD_BYTE  = 8'h80;
  localparam logic [SHP_INDEX_W-1:0] SHP_LEN_INDEX = 3'd7;
  localparam logic [2:0]             SHP_LAST_BYTE = 3'd7;

  // Input command codes
  localparam logic SHP_CMD_BYTE = 1'b0;
  localparam logic SHP_CMD_END  = 1'b1;

  // One queued job: a finished word, or the end of a message
  typedef struct packed {
    logic                   is_end;
    logic [SHP_WORD_W-1:0]  word;
    logic [SHP_INDEX_W-1:0] index;
    logic [SHP_WORD_W-1:0]  bit_len;
  } shp_entry_t;

endpackage
`default_nettype wire

/* hdl/shp_if.sv */
`default_nettype none
// Byte channel into the padder
interface shp_in_if;
  import shp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [SHP_BYTE_W-1:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// Padded word channel out of the padder
interface shp_out_if;
  import shp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SHP_WORD_W-1:0]  block_word;
  logic [SHP_INDEX_W-1:0] word_index;
  logic                   message_done;

  modport source (output valid, output block_word, output word_index,
                  output message_done, input ready);
  modport sink   (input valid, input block_word, input word_index,
                  input message_done, output ready);
endinterface
`default_nettype wire

/* hdl/shp_front.sv */
`default_nettype none
module shp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  shp_in_if.sink                  in_ch,
  input  wire logic               push_ready,
  output logic                    push_valid,
  output shp_pkg::shp_entry_t     push_entry
);
  import shp_pkg::*;

  logic [SHP_WORD_W-1:0] bit_count_r, bit_count_nxt;
  logic [SHP_POS_W-1:0]  pos_r, pos_nxt;
  logic [SHP_ASM_W-1:0]  asm_r, asm_nxt;
  logic                  accept;
  logic                  word_full;
  logic [SHP_POS_W-1:0]  pad_shift;
  logic [SHP_WORD_W-1:0] pad_word;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign word_full   = (pos_r[2:0] == SHP_LAST_BYTE);

  // Partial word with the marker byte, moved up to the top of the word
  assign pad_shift = {~pos_r[2:0], 3'b000};
  assign pad_word  = {asm_r, SHP_PAD_BYTE} << pad_shift;

  // Classify the transaction into a queue job
  always_comb begin
    push_valid         = 1'b0;
    push_entry.is_end  = 1'b0;
    push_entry.word    = {asm_r, in_ch.data_byte};
    push_entry.index   = pos_r[5:3];
    push_entry.bit_len = bit_count_r;
    if (accept) begin
      if (in_ch.cmd == SHP_CMD_END) begin
        push_valid        = 1'b1;
        push_entry.is_end = 1'b1;
        push_entry.word   = pad_word;
      end else begin
        push_valid = word_full;
      end
    end
  end

  // Running message state
  always_comb begin
    bit_count_nxt = bit_count_r;
    pos_nxt       = pos_r;
    asm_nxt       = asm_r;
    if (accept) begin
      if (in_ch.cmd == SHP_CMD_END) begin
        bit_count_nxt = '0;
        pos_nxt       = '0;
        asm_nxt       = '0;
      end else begin
        bit_count_nxt = bit_count_r + SHP_WORD_W'(SHP_BYTE_W);
        pos_nxt       = pos_r + SHP_POS_W'(1);
        asm_nxt       = word_full ? '0 : {asm_r[SHP_ASM_W-SHP_BYTE_W-1:0], in_ch.data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r <= '0;
      pos_r       <= '0;
      asm_r       <= '0;
    end else begin
      bit_count_r <= bit_count_nxt;
      pos_r       <= pos_nxt;
      asm_r       <= asm_nxt;
    end
  end

  // Length always counts whole bytes
  a_len_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r[2:0] == 3'b000)
    else $error("bit count not a byte multiple");

endmodule
`default_nettype wire

/* hdl/shp_queue.sv */
`default_nettype none
module shp_queue #(
  parameter int unsigned DEPTH = shp_pkg::SHP_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  input  wire shp_pkg::shp_entry_t push_entry,
  output logic                     push_ready,
  output logic                     pop_valid,
  output shp_pkg::shp_entry_t      pop_entry,
  input  wire logic                pop_ready
);
  import shp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  shp_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count out of range");

endmodule
`default_nettype wire

/* hdl/shp_back.sv */
`default_nettype none
module shp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                pop_valid,
  input  wire shp_pkg::shp_entry_t pop_entry,
  output logic                     pop_ready,
  shp_out_if.source                out_ch
);
  import shp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_PAD
  } state_t;

  state_t                 state_r;
  logic                   out_valid_r;
  logic [SHP_WORD_W-1:0]  word_r;
  logic [SHP_INDEX_W-1:0] index_r;
  logic                   done_r;
  logic [SHP_INDEX_W-1:0] pad_idx_r;
  logic [SHP_WORD_W-1:0]  len_r;
  logic                   advance;

  // Output register frees up when empty or taken this cycle
  assign advance   = !out_valid_r || out_ch.ready;
  assign pop_ready = advance && (state_r == ST_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.block_word   = word_r;
  assign out_ch.word_index   = index_r;
  assign out_ch.message_done = done_r;

  // Sequencer: plain words pass straight through; an end job sends its
  // marker word, then zero words up to slot 6 and the length word in slot 7
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      case (state_r)
        ST_IDLE: begin
          out_valid_r <= pop_valid;
          if (pop_valid) begin
            word_r  <= pop_entry.word;
            index_r <= pop_entry.index;
            done_r  <= 1'b0;
            if (pop_entry.is_end) begin
              pad_idx_r <= pop_entry.index + SHP_INDEX_W'(1);
              len_r     <= pop_entry.bit_len;
              state_r   <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          out_valid_r <= 1'b1;
          index_r     <= pad_idx_r;
          if (pad_idx_r == SHP_LEN_INDEX) begin
            word_r  <= len_r;
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            word_r    <= '0;
            done_r    <= 1'b0;
            pad_idx_r <= pad_idx_r + SHP_INDEX_W'(1);
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (index_r == SHP_LEN_INDEX))
    else $error("message end outside length slot");

  a_pad_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD) |-> out_valid_r)
    else $error("padding in progress with empty output register");

  a_len_word_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (word_r[2:0] == 3'b000))
    else $error("length word not a byte multiple");

endmodule
`default_nettype wire

/* hdl/sha256_message_padder_core.sv */
// SHA-256 message padder.
// in_ch carries one transaction per message byte (cmd = 0, data_byte) and one
// end-of-message transaction (cmd = 1) that closes the message.
// out_ch carries the padded message as 64-bit big-endian words, word_index
// 0..7 within each 512-bit block; message_done marks the length word that
// ends the last block.
// Throughput: one byte per cycle. Every eighth byte yields one word. The end
// transaction yields two to nine words, sent one per cycle by the back-end
// sequencer; meanwhile the front keeps taking bytes of the next message into
// a QUEUE_DEPTH-entry job queue, and in_ch.ready drops only when it is full.
// Path: the word that a transaction completes is written into the queue,
// then taken into the output register that drives out_ch.
// Stall: out_ch holds its word while ready is low; the queue then fills and
// in_ch.ready falls. Reset (rst_n low, synchronous) empties the queue and the
// output register and clears the byte position, length and partial word.
`default_nettype none
module sha256_message_padder_core #(
  parameter int unsigned QUEUE_DEPTH = shp_pkg::SHP_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  shp_in_if.sink    in_ch,
  shp_out_if.source out_ch
);
  import shp_pkg::*;

  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  shp_entry_t push_entry, pop_entry;

  // Byte intake and classification
  shp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  // Job queue decoupling intake from output
  shp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // Word emission and padding sequencer
  shp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
